[design/bfe_pkg.sv]
// ============================================================================
// bfe_pkg: shared types and constants of the Bloom filter engine
// Holds the item structs, opcodes, register indexes and controller states.
// ============================================================================
package bfe_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        REG_HASH_COUNT = 3'd0,
        REG_FILTER_LEN = 3'd1,
        REG_COEF_A0    = 3'd2,
        REG_COEF_B0    = 3'd3,
        REG_COEF_A1    = 3'd4,
        REG_COEF_B1    = 3'd5,
        REG_COEF_A2    = 3'd6,
        REG_COEF_B2    = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [63:0] key_chunk;
        logic        last_chunk;
    } in_item_t;

    typedef struct packed {
        logic present;
        logic accepted;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WIPE,
        ST_MUL,
        ST_ACC,
        ST_HCHK,
        ST_MOD,
        ST_PROBE_RD,
        ST_PROBE_WAIT,
        ST_PROBE_DO,
        ST_NEXT,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic wipe_step;
        logic mul_step;
        logic acc_step;
        logic mod_start;
        logic probe_read;
        logic probe_apply;
        logic next_hash;
        logic finish;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic mul_done;
        logic mod_done;
        logic wipe_done;
        logic last_hash;
        logic no_hash;
        logic len_zero;
        logic is_last;
        logic [1:0] op;
    } dp_stat_t;

endpackage

[design/bloom_filter_engine.sv]
// ============================================================================
// bloom_filter_engine: Bloom filter with multiply-add chunk hashing
// Top level joining the sequencing controller and the hashing datapath.
// ============================================================================
// A chunk passes through one shared multiplier for every hash function;
// a last chunk then runs each configured hash function through the
// one-bit-per-cycle remainder unit and its memory probe. Clear wipes
// one memory entry a cycle. One item at a time. Reset clears control
// state and then sweeps the bit store (busy high); done is a one-cycle
// strobe the receiver cannot stall, and result holds until the next finish.
module bloom_filter_engine #(
    parameter int MAX_HASHES      = 3,
    parameter int FILTER_BITS_MAX = 65536,
    parameter int CHUNK_BYTES     = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  bfe_pkg::in_item_t              item,
    output logic                           done,
    output bfe_pkg::out_item_t             result,
    input  logic                           cfg_we,
    input  logic [bfe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bfe_pkg::CFG_DATA_W-1:0] cfg_data
);

    // Besides the item opcode, controller and datapath share only these command
    // and status groups; the item is captured into the datapath on acceptance.
    bfe_pkg::dp_cmd_t  cmd;
    bfe_pkg::dp_stat_t stat;

    bfe_ctrl #(.MAX_HASHES(MAX_HASHES)) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (item.opcode),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    bfe_datapath #(
        .MAX_HASHES      (MAX_HASHES),
        .FILTER_BITS_MAX (FILTER_BITS_MAX),
        .CHUNK_BYTES     (CHUNK_BYTES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item),
        .cmd       (cmd),
        .stat      (stat),
        .res       (result)
    );

endmodule

[design/bfe_mod.sv]
// ============================================================================
// bfe_mod: sequential remainder unit
// Restoring division, one quotient bit per cycle, 64-bit dividend.
// ============================================================================
module bfe_mod #(
    parameter int LEN_W = 17
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [63:0]      dividend,
    input  logic [LEN_W-1:0] divisor,
    output logic             done,
    output logic [LEN_W-1:0] remainder
);

    logic [63:0]      num_reg, num_next;
    logic [LEN_W:0]   rem_reg, rem_next;
    logic [6:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [LEN_W:0]   trial;

    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg[LEN_W-1:0], num_reg[63]};
        if (start)
        begin
            num_next  = dividend;
            rem_next  = '0;
            cnt_next  = 7'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[62:0], 1'b0};
            if (trial >= {1'b0, divisor})
                rem_next = trial - {1'b0, divisor};
            else
                rem_next = trial;
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
    end

    assign done      = busy_reg && (cnt_reg == 7'd64) ? 1'b0 : (!busy_reg && cnt_reg == 7'd64);
    assign remainder = rem_reg[LEN_W-1:0];

endmodule

[design/bfe_datapath.sv]
// ============================================================================
// bfe_datapath: hash accumulation, remainder and bit store
// Holds the configuration, the running sums, one shared multiplier built
// from 32x32 partial products, the remainder unit and the membership memory.
// ============================================================================
module bfe_datapath #(
    parameter int MAX_HASHES      = 3,
    parameter int FILTER_BITS_MAX = 65536,
    parameter int CHUNK_BYTES     = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bfe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bfe_pkg::CFG_DATA_W-1:0] cfg_data,
    input  bfe_pkg::in_item_t              item,
    input  bfe_pkg::dp_cmd_t               cmd,
    output bfe_pkg::dp_stat_t              stat,
    output bfe_pkg::out_item_t             res
);

    localparam int AW    = $clog2(FILTER_BITS_MAX);
    localparam int LEN_W = AW + 1;
    localparam int HW    = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;
    localparam int CFG_FNS = 3;
    localparam logic [63:0] CHUNK_MASK = {64{1'b1}} >> (64 - 8 * CHUNK_BYTES);

    logic [1:0]  hcount_reg;
    logic [16:0] flen_reg;
    logic [63:0] coef_a_reg [MAX_HASHES];
    logic [63:0] coef_b_reg [MAX_HASHES];
    logic [63:0] sum_reg    [MAX_HASHES];

    logic [1:0]  op_reg;
    logic        last_reg;
    logic [63:0] chunk_reg;
    logic [HW-1:0] hsel_reg;
    logic [1:0]  part_reg;
    logic [63:0] prod_reg;
    logic [63:0] pp_reg;
    logic        allset_reg;
    logic        present_reg, accepted_reg;
    logic [AW:0] wipe_reg;

    logic [LEN_W-1:0] used_len;
    logic [1:0]       used_cnt;
    logic [63:0]      cur_a;
    logic [31:0]      mop_a, mop_b;
    logic             mod_done;
    logic [LEN_W-1:0] mod_rem;

    logic mem [FILTER_BITS_MAX];
    logic rd_bit_reg;

    always_comb
    begin
        if ({15'd0, flen_reg} > 32'(FILTER_BITS_MAX))
            used_len = LEN_W'(FILTER_BITS_MAX);
        else
            used_len = LEN_W'(flen_reg);
        if (32'(hcount_reg) > 32'(MAX_HASHES))
            used_cnt = 2'(MAX_HASHES);
        else
            used_cnt = hcount_reg;
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hcount_reg <= 2'd1;
            flen_reg   <= '0;
            for (int j = 0; j < MAX_HASHES; j++)
            begin
                coef_a_reg[j] <= '0;
                coef_b_reg[j] <= '0;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == bfe_pkg::REG_HASH_COUNT)
                hcount_reg <= cfg_data[1:0];
            else if (cfg_index == bfe_pkg::REG_FILTER_LEN)
                flen_reg <= cfg_data[16:0];
            else
            begin
                for (int j = 0; j < MAX_HASHES; j++)
                begin
                    if (j < CFG_FNS && 32'(cfg_index) == 32'(2 + 2 * j))
                        coef_a_reg[j] <= cfg_data;
                    if (j < CFG_FNS && 32'(cfg_index) == 32'(3 + 2 * j))
                        coef_b_reg[j] <= cfg_data;
                end
            end
        end
    end

    // Shared multiplier: the low 64 bits of a*c need three 32x32 products.
    assign cur_a = coef_a_reg[hsel_reg];
    always_comb
    begin
        case (part_reg)
            2'd0:    begin mop_a = cur_a[31:0];  mop_b = chunk_reg[31:0];  end
            2'd1:    begin mop_a = cur_a[63:32]; mop_b = chunk_reg[31:0];  end
            default: begin mop_a = cur_a[31:0];  mop_b = chunk_reg[63:32]; end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < MAX_HASHES; j++)
                sum_reg[j] <= '0;
            hsel_reg     <= '0;
            part_reg     <= '0;
            op_reg       <= '0;
            last_reg     <= 1'b0;
            allset_reg   <= 1'b1;
            present_reg  <= 1'b0;
            accepted_reg <= 1'b0;
            wipe_reg     <= '0;
        end
        else
        begin
            if (cmd.load_item)
            begin
                op_reg     <= item.opcode;
                last_reg   <= item.last_chunk;
                hsel_reg   <= '0;
                part_reg   <= '0;
                allset_reg <= 1'b1;
                wipe_reg   <= '0;
                if (item.opcode == bfe_pkg::OP_CLEAR)
                    for (int j = 0; j < MAX_HASHES; j++)
                        sum_reg[j] <= '0;
            end
            if (cmd.wipe_step)
                wipe_reg <= wipe_reg + 1'b1;
            // The partial product lags the part counter by one step, so the
            // low product lands on step one and the two cross terms follow.
            if (cmd.mul_step)
            begin
                part_reg <= part_reg + 2'd1;
                case (part_reg)
                    2'd0:    ;
                    2'd1:    prod_reg <= pp_reg;
                    default: prod_reg <= prod_reg + {pp_reg[31:0], 32'd0};
                endcase
            end
            if (cmd.acc_step)
            begin
                sum_reg[hsel_reg] <= sum_reg[hsel_reg] + prod_reg + coef_b_reg[hsel_reg];
                part_reg <= '0;
                if (32'(hsel_reg) == MAX_HASHES - 1)
                    hsel_reg <= '0;
                else
                    hsel_reg <= hsel_reg + 1'b1;
            end
            if (cmd.probe_apply && op_reg == bfe_pkg::OP_LOOKUP && !rd_bit_reg)
                allset_reg <= 1'b0;
            if (cmd.next_hash)
                hsel_reg <= hsel_reg + 1'b1;
            if (cmd.finish)
            begin
                for (int j = 0; j < MAX_HASHES; j++)
                    sum_reg[j] <= '0;
                present_reg  <= (op_reg == bfe_pkg::OP_LOOKUP) && used_len != '0
                                && allset_reg;
                accepted_reg <= (op_reg == bfe_pkg::OP_INSERT) && used_len != '0;
            end
        end
    end

    // Chunk and partial product registers; the partial product is fed one step ahead of the accumulate.
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
            chunk_reg <= item.key_chunk & CHUNK_MASK;
        pp_reg <= 64'(mop_a) * 64'(mop_b);
    end

    bfe_mod #(.LEN_W(LEN_W)) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.mod_start),
        .dividend  (sum_reg[hsel_reg]),
        .divisor   (used_len),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    // Membership memory: one read and one write port, read data registered.
    always_ff @(posedge clk)
    begin
        if (cmd.wipe_step)
            mem[wipe_reg[AW-1:0]] <= 1'b0;
        else if (cmd.probe_apply && op_reg == bfe_pkg::OP_INSERT)
            mem[mod_rem[AW-1:0]] <= 1'b1;
        if (cmd.probe_read)
            rd_bit_reg <= mem[mod_rem[AW-1:0]];
    end

    assign stat.mul_done  = (part_reg == 2'd3);
    assign stat.mod_done  = mod_done;
    assign stat.wipe_done = (32'(wipe_reg) == FILTER_BITS_MAX - 1);
    assign stat.last_hash = (32'(hsel_reg) + 1 >= 32'(used_cnt));
    assign stat.no_hash   = (used_cnt == 2'd0);
    assign stat.len_zero  = (used_len == '0);
    assign stat.is_last   = last_reg;
    assign stat.op        = op_reg;

    assign res.present  = present_reg;
    assign res.accepted = accepted_reg;

endmodule

[design/bfe_ctrl.sv]
// ============================================================================
// bfe_ctrl: sequencing controller
// Steps each item through multiply, accumulate, remainder and bit probes, or through the wipe for a clear.
// ============================================================================
module bfe_ctrl #(
    parameter int MAX_HASHES = 3
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [1:0]        opcode,
    input  bfe_pkg::dp_stat_t stat,
    output bfe_pkg::dp_cmd_t  cmd,
    output logic              busy,
    output logic              done
);

    localparam int HW = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;

    bfe_pkg::state_t state_reg, state_next;
    logic [HW-1:0]   fn_reg, fn_next;
    logic            accept;

    assign accept = start && (state_reg == bfe_pkg::ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        fn_next    = fn_reg;
        unique case (state_reg)
            bfe_pkg::ST_IDLE:
            begin
                fn_next = '0;
                if (start)
                begin
                    if (opcode == bfe_pkg::OP_CLEAR)
                        state_next = bfe_pkg::ST_WIPE;
                    else if (opcode != bfe_pkg::OP_NONE)
                        state_next = bfe_pkg::ST_MUL;
                end
            end
            bfe_pkg::ST_WIPE:
                if (stat.wipe_done)
                    state_next = bfe_pkg::ST_IDLE;
            bfe_pkg::ST_MUL:
                if (stat.mul_done)
                    state_next = bfe_pkg::ST_ACC;
            bfe_pkg::ST_ACC:
            begin
                if (32'(fn_reg) == MAX_HASHES - 1)
                begin
                    fn_next = '0;
                    state_next = bfe_pkg::ST_HCHK;
                end
                else
                begin
                    fn_next = fn_reg + 1'b1;
                    state_next = bfe_pkg::ST_MUL;
                end
            end
            bfe_pkg::ST_HCHK:
            begin
                if (!stat.is_last)
                    state_next = bfe_pkg::ST_IDLE;
                else if (stat.len_zero || stat.no_hash)
                    state_next = bfe_pkg::ST_DONE;
                else
                    state_next = bfe_pkg::ST_MOD;
            end
            bfe_pkg::ST_MOD:
                if (stat.mod_done)
                    state_next = bfe_pkg::ST_PROBE_RD;
            bfe_pkg::ST_PROBE_RD:   state_next = bfe_pkg::ST_PROBE_WAIT;
            bfe_pkg::ST_PROBE_WAIT: state_next = bfe_pkg::ST_PROBE_DO;
            bfe_pkg::ST_PROBE_DO:
                state_next = stat.last_hash ? bfe_pkg::ST_DONE : bfe_pkg::ST_NEXT;
            bfe_pkg::ST_NEXT:       state_next = bfe_pkg::ST_HCHK;
            bfe_pkg::ST_DONE:       state_next = bfe_pkg::ST_IDLE;
            default:                state_next = bfe_pkg::ST_IDLE;
        endcase
    end

    // The remainder unit starts on entry to ST_MOD; it is pulsed from
    // HCHK, which NEXT returns to once the next sum is selected, and it
    // completes while the controller waits.
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            bfe_pkg::ST_IDLE:    cmd.load_item = accept;
            bfe_pkg::ST_WIPE:    cmd.wipe_step = 1'b1;
            bfe_pkg::ST_MUL:     cmd.mul_step  = 1'b1;
            bfe_pkg::ST_ACC:     cmd.acc_step  = 1'b1;
            bfe_pkg::ST_HCHK:
                cmd.mod_start = stat.is_last && !stat.len_zero && !stat.no_hash;
            bfe_pkg::ST_PROBE_RD:   cmd.probe_read  = 1'b1;
            bfe_pkg::ST_PROBE_DO:   cmd.probe_apply = 1'b1;
            bfe_pkg::ST_NEXT:
            begin
                cmd.next_hash = 1'b1;
            end
            bfe_pkg::ST_DONE:    cmd.finish = 1'b1;
            default:             cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bfe_pkg::ST_WIPE;
            fn_reg    <= '0;
            done      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fn_reg    <= fn_next;
            done      <= (state_reg == bfe_pkg::ST_DONE);
        end
    end

    assign busy = (state_reg != bfe_pkg::ST_IDLE);

    a_done_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bfe_pkg::ST_DONE) |=> done)
        else $error("result strobe missing after finish");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !cmd.load_item)
        else $error("item loaded while busy");
    a_single_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command");

endmodule
